>>> rtl/core/platform_interrupt_controller_top_macros.svh
// Assertion macros used by the interrupt controller checker.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interrupt controller check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interrupt controller check failed");

// Implication checked at the edge where the result of an accepted word is taken.
`define PIC_ASSERT_RESULT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> ##1 (cons)) \
    else $error("interrupt controller check failed");

`endif

>>> rtl/core/pic_pkg.sv
// Package with the shared types and constants of the interrupt controller.
`default_nettype none

package pic_pkg;

  // Default configuration.
  localparam int NumSourcesDef = 32;
  localparam int PrioBitsDef   = 3;

  // Source lines and source ids travel in fixed 32 bit words with 5 bit ids.
  localparam int LineBits = 32;
  localparam int SrcIdW   = 5;
  localparam int WordBits = 32;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActLines = 2'd2
  } pic_action_e;

  // Register region addressed by a bus access.
  typedef enum logic [1:0] {
    RegPrio   = 2'd0,
    RegEnable = 2'd1,
    RegThresh = 2'd2,
    RegClaim  = 2'd3
  } pic_region_e;

  // Winner of the priority selection.
  typedef struct packed {
    logic              found;
    logic [SrcIdW-1:0] id;
  } pic_claim_t;

endpackage

`default_nettype wire

>>> rtl/core/platform_interrupt_controller_top.sv
// Interrupt controller for one hart context: input register, update logic, result register.
// A word accepted into the input register is applied to the state as it moves on to the
// result register, which strobes and holds its result.
// Throughput: one word every cycle. busy stays low; the priority tree sits between the
// input and result registers. Reset (asynchronous, active low) clears priorities, enables,
// pending, in-service bits and the threshold at once; no clearing pass is needed.
`default_nettype none

module platform_interrupt_controller_top #(
  parameter int NUM_SOURCES = pic_pkg::NumSourcesDef,
  parameter int PRIO_BITS   = pic_pkg::PrioBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [1:0]  region_i,
  input  logic [4:0]  index_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] source_lines_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        interrupt_request_o
);
  import pic_pkg::*;

  // Only sources below the line width can ever become pending or be addressed.
  localparam int NumSrc  = (NUM_SOURCES < LineBits) ? NUM_SOURCES : LineBits;
  localparam int EnWords = (NUM_SOURCES + WordBits - 1) / WordBits;

  // Bits of an enable word that belong to real sources.
  function automatic logic [WordBits-1:0] word_mask(input int w);
    logic [WordBits-1:0] m;
    m = '0;
    for (int b = 0; b < WordBits; b++) begin
      if ((w * WordBits + b) != 0 && (w * WordBits + b) < NUM_SOURCES) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

  // Input register.
  logic                in_vld_q;
  logic [1:0]          act_q;
  logic [1:0]          reg_q;
  logic [4:0]          idx_q;
  logic [31:0]         wdata_q;
  logic [LineBits-1:0] lines_q;

  // Controller state.
  logic [NumSrc-1:0][PRIO_BITS-1:0]  prio_q, prio_d;
  logic [EnWords-1:0][WordBits-1:0] enable_q, enable_d;
  logic [NumSrc-1:0]                 pend_q, pend_d;
  logic [NumSrc-1:0]                 insv_q, insv_d;
  logic [PRIO_BITS-1:0]              thresh_q, thresh_d;

  // Result register.
  logic        done_q;
  logic [31:0] rdata_q, rdata_d;

  pic_claim_t  claim;
  pic_action_e act;
  pic_region_e region;

  assign busy   = 1'b0;
  assign act    = pic_action_e'(act_q);
  assign region = pic_region_e'(reg_q);

  // Selection over the current state.
  pic_arbiter #(
    .NUM_SRC  (NumSrc),
    .PRIO_BITS(PRIO_BITS)
  ) u_arbiter (
    .enable_i (enable_q[0][NumSrc-1:0]),
    .pending_i(pend_q),
    .prio_i   (prio_q),
    .thresh_i (thresh_q),
    .claim_o  (claim)
  );

  // Apply the registered word to the state and form the read value.
  always_comb begin
    prio_d   = prio_q;
    enable_d = enable_q;
    pend_d   = pend_q;
    insv_d   = insv_q;
    thresh_d = thresh_q;
    rdata_d  = '0;
    if (in_vld_q) begin
      case (act)
        ActRead: begin
          case (region)
            RegPrio: begin
              for (int s = 1; s < NumSrc; s++) begin
                if (idx_q == 5'(s)) rdata_d = 32'(prio_q[s]);
              end
            end
            RegEnable: begin
              for (int w = 0; w < EnWords; w++) begin
                if (idx_q == 5'(w)) rdata_d = enable_q[w];
              end
            end
            RegThresh: rdata_d = 32'(thresh_q);
            RegClaim: begin
              rdata_d = 32'(claim.id);
              for (int s = 1; s < NumSrc; s++) begin
                if (claim.found && claim.id == SrcIdW'(s)) begin
                  pend_d[s] = 1'b0;
                  insv_d[s] = 1'b1;
                end
              end
            end
            default: rdata_d = '0;
          endcase
        end
        ActWrite: begin
          case (region)
            RegPrio: begin
              for (int s = 1; s < NumSrc; s++) begin
                if (idx_q == 5'(s)) prio_d[s] = wdata_q[PRIO_BITS-1:0];
              end
            end
            RegEnable: begin
              for (int w = 0; w < EnWords; w++) begin
                if (idx_q == 5'(w)) enable_d[w] = wdata_q & word_mask(w);
              end
            end
            RegThresh: thresh_d = wdata_q[PRIO_BITS-1:0];
            RegClaim: begin
              // Completion releases an enabled source; bad ids are ignored.
              for (int s = 1; s < NumSrc; s++) begin
                if (wdata_q == 32'(s) && enable_q[0][s]) insv_d[s] = 1'b0;
              end
            end
            default: rdata_d = '0;
          endcase
        end
        ActLines: begin
          // Gateways: a high line sets pending unless pending or in service.
          for (int s = 1; s < NumSrc; s++) begin
            if (lines_q[s] && !pend_q[s] && !insv_q[s]) pend_d[s] = 1'b1;
          end
        end
        default: rdata_d = '0;
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
      prio_q   <= '0;
      enable_q <= '0;
      pend_q   <= '0;
      insv_q   <= '0;
      thresh_q <= '0;
    end else begin
      in_vld_q <= start & ~busy;
      done_q   <= in_vld_q;
      prio_q   <= prio_d;
      enable_q <= enable_d;
      pend_q   <= pend_d;
      insv_q   <= insv_d;
      thresh_q <= thresh_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      act_q   <= action_i;
      reg_q   <= region_i;
      idx_q   <= index_i;
      wdata_q <= write_data_i;
      lines_q <= source_lines_i;
    end
    if (in_vld_q) begin
      rdata_q <= rdata_d;
    end
  end

  // The request reflects the state left by the word whose result is shown.
  assign done_o              = done_q;
  assign read_data_o         = rdata_q;
  assign interrupt_request_o = claim.found;

endmodule

`default_nettype wire

>>> rtl/core/pic_arbiter.sv
// Priority selection tree: picks the enabled pending source of highest priority.
`default_nettype none

module pic_arbiter #(
  parameter int NUM_SRC   = 32,
  parameter int PRIO_BITS = 3
) (
  input  logic [NUM_SRC-1:0]                enable_i,
  input  logic [NUM_SRC-1:0]                pending_i,
  input  logic [NUM_SRC-1:0][PRIO_BITS-1:0] prio_i,
  input  logic [PRIO_BITS-1:0]              thresh_i,
  output pic_pkg::pic_claim_t               claim_o
);
  import pic_pkg::*;

  localparam int NumLeaf = 2 ** $clog2(NUM_SRC);

  // Heap-ordered tree: node n has children 2n and 2n+1, leaves from NumLeaf.
  logic                 node_vld  [1:2*NumLeaf-1];
  logic [PRIO_BITS-1:0] node_prio [1:2*NumLeaf-1];
  logic [SrcIdW-1:0]    node_id   [1:2*NumLeaf-1];

  // Leaves: a source competes when enabled, pending and above the threshold.
  for (genvar s = 0; s < NumLeaf; s++) begin : g_leaf
    if (s >= 1 && s < NUM_SRC) begin : g_real
      assign node_vld[NumLeaf+s]  = enable_i[s] & pending_i[s] & (prio_i[s] > thresh_i);
      assign node_prio[NumLeaf+s] = prio_i[s];
    end else begin : g_none
      assign node_vld[NumLeaf+s]  = 1'b0;
      assign node_prio[NumLeaf+s] = '0;
    end
    assign node_id[NumLeaf+s] = SrcIdW'(s);
  end

  // Inner nodes: the lower numbered side wins unless the other is strictly higher.
  for (genvar n = 1; n < NumLeaf; n++) begin : g_node
    logic pick_hi;
    assign pick_hi = node_vld[2*n+1] &
                     (!node_vld[2*n] || (node_prio[2*n+1] > node_prio[2*n]));
    assign node_vld[n]  = node_vld[2*n] | node_vld[2*n+1];
    assign node_prio[n] = pick_hi ? node_prio[2*n+1] : node_prio[2*n];
    assign node_id[n]   = pick_hi ? node_id[2*n+1] : node_id[2*n];
  end

  assign claim_o.found = node_vld[1];
  assign claim_o.id    = node_vld[1] ? node_id[1] : '0;

endmodule

`default_nettype wire

>>> rtl/core/pic_checker.sv
// Port-level checker for the interrupt controller, bound to the top level.
`default_nettype none
`include "platform_interrupt_controller_top_macros.svh"

module pic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action_i,
  input logic [1:0]  region_i,
  input logic [31:0] write_data_i,
  input logic        done_o,
  input logic [31:0] read_data_o,
  input logic        interrupt_request_o
);
  import pic_pkg::*;

  logic accept;
  assign accept = start & ~busy;

  // Every accepted word gives exactly one strobe, at the edge where its result is taken.
  `PIC_ASSERT_RESULT(a_result_follows, accept, done_o)
  `PIC_ASSERT_RESULT(a_no_spurious_result, !accept, !done_o)

  // A claim that finds nothing means no source was above the threshold.
  `PIC_ASSERT_RESULT(a_empty_claim_no_irq,
      accept && action_i == ActRead && region_i == RegClaim,
      read_data_o != 32'd0 || !interrupt_request_o)

  // With the threshold at its maximum no source can raise a request.
  `PIC_ASSERT_RESULT(a_max_thresh_no_irq,
      accept && action_i == ActWrite && region_i == RegThresh && write_data_i == 32'hFFFFFFFF,
      !interrupt_request_o)

endmodule

bind platform_interrupt_controller_top pic_checker u_pic_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .action_i           (action_i),
  .region_i           (region_i),
  .write_data_i       (write_data_i),
  .done_o             (done_o),
  .read_data_o        (read_data_o),
  .interrupt_request_o(interrupt_request_o)
);

`default_nettype wire

>>> tb/platform_interrupt_controller_top_tb.sv
// Testbench for the interrupt controller: directed and random bus words checked against a mirror.
`default_nettype none

module platform_interrupt_controller_top_tb;
  import pic_pkg::*;

  localparam int NSrc    = NumSourcesDef;
  localparam int PBits   = PrioBitsDef;
  localparam int EnWords = (NSrc + 31) / 32;
  // The package names no action for the fourth code; the block must ignore it.
  localparam logic [1:0] ActUnused = 2'd3;
  localparam int DrainCycles = 4;

  // One expected result word.
  typedef struct {
    logic [31:0] rdata;
    logic        irq;
  } bus_reply_t;

  // Mirror of the hart context: tracks priorities, enables, pending and in-service
  // bits, works out the reply to every accepted word and checks the replies in order.
  class hart_context_mirror;
    bit [PBits-1:0] prio_of [NSrc];
    bit [NSrc-1:0]  enabled;
    bit [NSrc-1:0]  pending;
    bit [NSrc-1:0]  in_service;
    bit [PBits-1:0] threshold;
    bus_reply_t     due_replies[$];
    int unsigned    mismatches;

    // Highest priority enabled pending source above the threshold, lowest id on ties.
    function int unsigned top_source();
      int unsigned best;
      bit [PBits-1:0] best_p;
      best = 0;
      best_p = threshold;
      for (int id = 1; id < NSrc; id++) begin
        if (enabled[id] && pending[id] && prio_of[id] > best_p) begin
          best = id;
          best_p = prio_of[id];
        end
      end
      return best;
    endfunction

    // A random source now in service, or zero when there is none.
    function int unsigned any_in_service();
      int unsigned ids[$];
      for (int id = 1; id < NSrc; id++)
        if (in_service[id]) ids.push_back(id);
      if (ids.size() == 0) return 0;
      return ids[$urandom_range(ids.size() - 1)];
    endfunction

    function void note_word(logic [1:0] act, logic [1:0] region, logic [4:0] idx,
                            logic [31:0] wdata, logic [31:0] lines);
      bus_reply_t r;
      int unsigned id;
      r.rdata = '0;
      if (act == ActRead) begin
        case (region)
          RegPrio: if (idx != 0 && idx < NSrc) r.rdata = 32'(prio_of[idx]);
          RegEnable: begin
            if (idx < EnWords)
              for (int b = 0; b < 32; b++) begin
                id = idx * 32 + b;
                if (id != 0 && id < NSrc) r.rdata[b] = enabled[id];
              end
          end
          RegThresh: r.rdata = 32'(threshold);
          default: begin
            // A claim hands over the winner and blocks its gateway.
            id = top_source();
            r.rdata = id;
            if (id != 0) begin
              pending[id] = 1'b0;
              in_service[id] = 1'b1;
            end
          end
        endcase
      end else if (act == ActWrite) begin
        case (region)
          RegPrio: if (idx != 0 && idx < NSrc) prio_of[idx] = wdata[PBits-1:0];
          RegEnable: begin
            if (idx < EnWords)
              for (int b = 0; b < 32; b++) begin
                id = idx * 32 + b;
                if (id != 0 && id < NSrc) enabled[id] = wdata[b];
              end
          end
          RegThresh: threshold = wdata[PBits-1:0];
          default: begin
            // Completion only counts for a valid, enabled id.
            if (wdata != 0 && wdata < NSrc) begin
              id = wdata;
              if (enabled[id]) in_service[id] = 1'b0;
            end
          end
        endcase
      end else if (act == ActLines) begin
        for (int n = 1; n < 32 && n < NSrc; n++)
          if (lines[n] && !pending[n] && !in_service[n]) pending[n] = 1'b1;
      end
      r.irq = (top_source() != 0);
      due_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_reply(logic [31:0] rdata, logic irq);
      bus_reply_t r;
      if (due_replies.size() == 0) begin
        report_mismatch("result word with nothing expected", rdata, '0);
      end else begin
        r = due_replies.pop_front();
        if (rdata !== r.rdata) report_mismatch("read_data", rdata, r.rdata);
        if (irq !== r.irq) report_mismatch("interrupt_request", 32'(irq), 32'(r.irq));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = '0;
  logic [1:0]  region_i = '0;
  logic [4:0]  index_i = '0;
  logic [31:0] write_data_i = '0;
  logic [31:0] source_lines_i = '0;
  logic        done_o;
  logic [31:0] read_data_o;
  logic        interrupt_request_o;

  hart_context_mirror mirror = new;

  platform_interrupt_controller_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .region_i           (region_i),
    .index_i            (index_i),
    .write_data_i       (write_data_i),
    .source_lines_i     (source_lines_i),
    .done_o             (done_o),
    .read_data_o        (read_data_o),
    .interrupt_request_o(interrupt_request_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note every accepted word and check every strobed result at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) mirror.check_reply(read_data_o, interrupt_request_o);
      if (start && busy === 1'b0)
        mirror.note_word(action_i, region_i, index_i, write_data_i, source_lines_i);
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic push_word(input logic [1:0] act, input logic [1:0] region,
                           input logic [4:0] idx, input logic [31:0] wdata,
                           input logic [31:0] lines);
    start          <= 1'b1;
    action_i       <= act;
    region_i       <= region;
    index_i        <= idx;
    write_data_i   <= wdata;
    source_lines_i <= lines;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // Each cycle is idle with the given chance in a hundred.
  task automatic maybe_idle(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // One random word, biased towards claim and complete traffic on live sources.
  task automatic random_word();
    logic [1:0]  act;
    logic [1:0]  region;
    logic [4:0]  idx;
    logic [31:0] wdata;
    logic [31:0] lines;
    int unsigned pick;
    act    = ActRead;
    region = RegClaim;
    idx    = 5'($urandom);
    wdata  = $urandom;
    lines  = $urandom;
    pick   = $urandom_range(99);
    if (pick < 20) begin
      act = ActLines;
      if ($urandom_range(1)) lines = $urandom & $urandom;
    end else if (pick < 40) begin
      act = ActRead;
      region = RegClaim;
    end else if (pick < 55) begin
      act = ActWrite;
      region = RegClaim;
      if ($urandom_range(9) < 7) begin
        wdata = mirror.any_in_service();
        if (wdata == 0) wdata = $urandom_range(0, 40);
      end else if ($urandom_range(1)) begin
        wdata = $urandom_range(0, 40);
      end
    end else if (pick < 70) begin
      act = ActWrite;
      region = RegPrio;
      if ($urandom_range(3) != 0) wdata = $urandom_range(0, 7);
    end else if (pick < 78) begin
      act = ActWrite;
      region = RegEnable;
      if ($urandom_range(7) != 0) idx = 0;
      if ($urandom_range(3) == 0) wdata = $urandom | $urandom;
    end else if (pick < 83) begin
      act = ActWrite;
      region = RegThresh;
      if ($urandom_range(3) != 0) wdata = $urandom_range(0, 2);
    end else if (pick < 95) begin
      act = ActRead;
      region = 2'($urandom_range(0, 2));
      if (region == RegEnable && $urandom_range(1)) idx = 0;
    end else begin
      act = ActUnused;
      region = 2'($urandom);
    end
    push_word(act, region, idx, wdata, lines);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: register extremes, gateway blocking, claims and completions.
    push_word(ActWrite, RegPrio, 5'd0, 32'hFFFF_FFFF, '0);     // source zero ignores writes
    push_word(ActRead, RegPrio, 5'd0, '0, '0);
    push_word(ActWrite, RegPrio, 5'd5, 32'hFFFF_FFFF, '0);     // wide value keeps low bits
    push_word(ActWrite, RegPrio, 5'd31, 32'd3, '0);
    push_word(ActWrite, RegPrio, 5'd9, 32'd3, '0);
    push_word(ActRead, RegPrio, 5'd5, '0, '0);
    push_word(ActWrite, RegEnable, 5'd0, 32'hFFFF_FFFF, '0);   // bit of source zero stays clear
    push_word(ActWrite, RegEnable, 5'd31, 32'hFFFF_FFFF, '0);  // enable word out of range
    push_word(ActRead, RegEnable, 5'd0, '0, '0);
    push_word(ActRead, RegEnable, 5'd31, '0, '0);
    push_word(ActWrite, RegThresh, '0, 32'hFFFF_FFF9, '0);
    push_word(ActRead, RegThresh, '0, '0, '0);
    push_word(ActLines, RegClaim, '0, '0, 32'hFFFF_FFFF);
    push_word(ActRead, RegClaim, '0, '0, '0);                 // highest priority wins
    push_word(ActRead, RegClaim, '0, '0, '0);                 // tie goes to the lower id
    push_word(ActLines, RegClaim, '0, '0, 32'hFFFF_FFFF);      // in-service gateways blocked
    push_word(ActWrite, RegClaim, '0, 32'd0, '0);              // bad ids are ignored
    push_word(ActWrite, RegClaim, '0, 32'd32, '0);
    push_word(ActWrite, RegClaim, '0, 32'd5, '0);
    push_word(ActLines, RegClaim, '0, '0, 32'hFFFF_FFFF);      // line still high re-pends
    push_word(ActWrite, RegThresh, '0, 32'd7, '0);
    push_word(ActRead, RegClaim, '0, '0, '0);                 // nothing above the threshold
    push_word(ActUnused, RegClaim, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(ActWrite, RegThresh, '0, 32'd0, '0);
    push_word(ActLines, RegClaim, 5'd31, 32'hFFFF_FFFF, 32'd0);

    // Random words: sender idles now and then, then often, then never.
    for (int i = 0; i < 520; i++) begin
      random_word();
      maybe_idle(37);
    end
    for (int i = 0; i < 520; i++) begin
      random_word();
      maybe_idle(88);
    end
    for (int i = 0; i < 510; i++) random_word();
    start <= 1'b0;

    while (mirror.due_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mirror.mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
